// ===== rtl/bbls_pkg.sv =====
// Shared types and constants for the burst-to-bank line splitter.
`timescale 1ns / 1ps

package bbls_pkg;

    // Result status codes
    localparam logic [1:0] STAT_ACCESS   = 2'd0;
    localparam logic [1:0] STAT_ACCEPTED = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;
    localparam logic [1:0] STAT_NO_BURST = 2'd3;

    // Input modes
    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_ISSUE   = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BANK_WIDTH_LOG2 = 2'd0;
    localparam logic [1:0] CFG_BANK_COUNT_LOG2 = 2'd1;
    localparam logic [1:0] CFG_LOCAL_BASE      = 2'd2;
    localparam logic [1:0] CFG_QUEUE_LIMIT     = 2'd3;

    // Largest bank width log2 the splitter honors
    localparam logic [2:0] WIDTH_LOG2_MAX = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;     // latch the input transaction
        logic       push;        // write the captured burst at the tail
        logic       cut;         // cut one line from the active burst
        logic       activate;    // load the head burst if none is active
        logic       emit_flag;   // send a non-access result
        logic [1:0] flag_status;
        logic       emit_access; // send the next bank access of the line
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic mode;          // captured mode
        logic enq_ok;        // burst may be queued
        logic active;        // an active burst exists
        logic limit_zero;    // captured line limit is zero
        logic cut_finishes;  // the line about to be cut ends the burst
        logic last_access;   // current access closes the line
    } t_dp_stat;

endpackage

// ===== rtl/bbls_ctrl.sv =====
// Sequencing state machine of the burst-to-bank line splitter.
`timescale 1ns / 1ps

module bbls_ctrl
    import bbls_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECODE   = 3'd1;
    localparam logic [2:0] ST_LOAD_ENQ = 3'd2;
    localparam logic [2:0] ST_LOAD_ISS = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.mode == MODE_ENQUEUE) begin
                    if (i_stat.enq_ok) begin
                        o_cmd.push = 1'b1;
                        n_state    = ST_LOAD_ENQ;
                    end else begin
                        o_cmd.emit_flag   = 1'b1;
                        o_cmd.flag_status = STAT_REJECTED;
                        n_state           = ST_IDLE;
                    end
                end else if (!i_stat.active) begin
                    o_cmd.emit_flag   = 1'b1;
                    o_cmd.flag_status = STAT_NO_BURST;
                    n_state           = ST_IDLE;
                end else if (i_stat.limit_zero) begin
                    o_cmd.emit_flag   = 1'b1;
                    o_cmd.flag_status = STAT_REJECTED;
                    n_state           = ST_IDLE;
                end else begin
                    o_cmd.cut = 1'b1;
                    n_state   = i_stat.cut_finishes ? ST_LOAD_ISS : ST_EMIT;
                end
            end
            ST_LOAD_ENQ: begin
                o_cmd.activate    = 1'b1;
                o_cmd.emit_flag   = 1'b1;
                o_cmd.flag_status = STAT_ACCEPTED;
                n_state           = ST_IDLE;
            end
            ST_LOAD_ISS: begin
                o_cmd.activate = 1'b1;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit_access = 1'b1;
                if (i_stat.last_access) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bbls_dpath.sv =====
// Datapath of the burst-to-bank line splitter: queue, active burst, line cutter, result register.
`timescale 1ns / 1ps

module bbls_dpath
    import bbls_pkg::*;
#(
    parameter int NUM_BANKS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_mode,
    input  logic [31:0] i_burst_base,
    input  logic [23:0] i_burst_bytes,
    input  logic        i_write_flag,
    input  logic [23:0] i_line_limit,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [4:0]  o_bank_index,
    output logic [31:0] o_bank_addr,
    output logic [4:0]  o_access_bytes,
    output logic        o_access_write,
    output logic        o_line_end,
    output logic        o_burst_done,
    output logic [4:0]  o_queue_used
);

    localparam int CL_MAX = $clog2(NUM_BANKS + 1) - 1;        // floor(log2(NUM_BANKS))
    localparam int SZ_W   = 32'(WIDTH_LOG2_MAX) + CL_MAX + 1; // holds one full line
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W  = PTR_W + 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Configuration
    logic [2:0]  r_cfg_bw;
    logic [2:0]  r_cfg_bc;
    logic [31:0] r_cfg_base;
    logic [4:0]  r_cfg_qlim;

    // Captured transaction
    logic        r_mode;
    logic [31:0] r_base;
    logic [23:0] r_bytes;
    logic        r_wr_in;
    logic [23:0] r_llimit;

    // Burst queue
    logic [31:0] r_q_base  [QUEUE_DEPTH];
    logic [23:0] r_q_len   [QUEUE_DEPTH];
    logic        r_q_write [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;

    // Active burst and current line
    logic [31:0]     r_act_addr;
    logic [23:0]     r_act_rem;
    logic [31:0]     r_cur_addr;
    logic [SZ_W-1:0] r_line_left;
    logic            r_line_wr;
    logic            r_line_done;

    // Result register
    logic        r_strobe;
    logic [1:0]  r_status;
    logic [4:0]  r_bank;
    logic [31:0] r_baddr;
    logic [4:0]  r_abytes;
    logic        r_awrite;
    logic        r_lend;
    logic        r_bdone;
    logic [4:0]  r_qused;

    logic [2:0]       wl;
    logic [2:0]       cl;
    logic [SZ_W-1:0]  lw;
    logic [SZ_W-1:0]  to_bound;
    logic [23:0]      m1, m2, m3;
    logic [SZ_W-1:0]  line_size;
    logic [4:0]       width5;
    logic [4:0]       chunk_raw;
    logic [4:0]       chunk;
    logic             last_access;
    logic [4:0]       bank_mask;
    logic [31:0]      addr_shift;
    logic [4:0]       bank;
    logic [4:0]       qlim;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] head_next;

    // Geometry: bank width saturates at 16 bytes, bank count at the bank instance count
    assign wl = (r_cfg_bw > WIDTH_LOG2_MAX) ? WIDTH_LOG2_MAX : r_cfg_bw;
    assign cl = (r_cfg_bc > 3'(CL_MAX)) ? 3'(CL_MAX) : r_cfg_bc;
    assign lw = SZ_W'(1) << ({1'b0, wl} + {1'b0, cl});
    assign to_bound = lw - (r_act_addr[SZ_W-1:0] & (lw - SZ_W'(1)));

    // Line length: least of remaining, limit, line width, distance to boundary
    assign m1 = (r_act_rem < r_llimit) ? r_act_rem : r_llimit;
    assign m2 = (m1 < 24'(lw)) ? m1 : 24'(lw);
    assign m3 = (m2 < 24'(to_bound)) ? m2 : 24'(to_bound);
    assign line_size = m3[SZ_W-1:0];

    // One access per bank word
    assign width5      = 5'(1) << wl;
    assign chunk_raw   = width5 - (r_cur_addr[4:0] & (width5 - 5'd1));
    assign last_access = (SZ_W'(chunk_raw) >= r_line_left);
    assign chunk       = last_access ? r_line_left[4:0] : chunk_raw;
    assign bank_mask   = 5'((6'd1 << cl) - 6'd1);
    assign addr_shift  = r_cur_addr >> wl;
    assign bank        = addr_shift[4:0] & bank_mask;

    // Queue pointers
    assign qlim      = (r_cfg_qlim < 5'(QUEUE_DEPTH)) ? r_cfg_qlim : 5'(QUEUE_DEPTH);
    assign tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign head_next = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);

    assign o_stat.mode         = r_mode;
    assign o_stat.enq_ok       = (r_bytes != 24'd0) && (5'(r_count) < qlim);
    assign o_stat.active       = (r_act_rem != 24'd0) && (r_count != '0);
    assign o_stat.limit_zero   = (r_llimit == 24'd0);
    assign o_stat.cut_finishes = (r_act_rem == 24'(line_size));
    assign o_stat.last_access  = last_access;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bw   <= 3'd2;
            r_cfg_bc   <= 3'd4;
            r_cfg_base <= 32'd0;
            r_cfg_qlim <= 5'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BANK_WIDTH_LOG2: r_cfg_bw   <= i_cfg_data[2:0];
                CFG_BANK_COUNT_LOG2: r_cfg_bc   <= i_cfg_data[2:0];
                CFG_LOCAL_BASE:      r_cfg_base <= i_cfg_data;
                CFG_QUEUE_LIMIT:     r_cfg_qlim <= i_cfg_data[4:0];
            endcase
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_base   <= i_burst_base;
            r_bytes  <= i_burst_bytes;
            r_wr_in  <= i_write_flag;
            r_llimit <= i_line_limit;
        end
        if (i_cmd.push) begin
            r_q_base[tail]  <= r_base;
            r_q_len[tail]   <= r_bytes;
            r_q_write[tail] <= r_wr_in;
        end
        if (i_cmd.cut) begin
            r_cur_addr  <= r_act_addr;
            r_line_left <= line_size;
            r_line_wr   <= r_q_write[r_head];
            r_line_done <= o_stat.cut_finishes;
        end else if (i_cmd.emit_access) begin
            r_cur_addr  <= r_cur_addr + 32'(chunk);
            r_line_left <= r_line_left - SZ_W'(chunk);
        end
        if (i_cmd.emit_flag) begin
            r_status <= i_cmd.flag_status;
            r_bank   <= 5'd0;
            r_baddr  <= 32'd0;
            r_abytes <= 5'd0;
            r_awrite <= 1'b0;
            r_lend   <= 1'b1;
            r_bdone  <= 1'b0;
            r_qused  <= 5'(r_count);
        end else if (i_cmd.emit_access) begin
            r_status <= STAT_ACCESS;
            r_bank   <= bank;
            r_baddr  <= r_cur_addr - r_cfg_base;
            r_abytes <= chunk;
            r_awrite <= r_line_wr;
            r_lend   <= last_access;
            r_bdone  <= r_line_done;
            r_qused  <= 5'(r_count);
        end
    end

    // Control state: queue occupancy and active burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_act_addr <= 32'd0;
            r_act_rem  <= 24'd0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_flag | i_cmd.emit_access;
            if (i_cmd.push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cut) begin
                r_act_addr <= r_act_addr + 32'(line_size);
                r_act_rem  <= r_act_rem - 24'(line_size);
                if (o_stat.cut_finishes) begin
                    r_head  <= head_next;
                    r_count <= r_count - CNT_W'(1);
                end
            end else if (i_cmd.activate) begin
                if (r_act_rem == 24'd0 && r_count != '0) begin
                    r_act_addr <= r_q_base[r_head];
                    r_act_rem  <= r_q_len[r_head];
                end
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_bank_index   = r_bank;
    assign o_bank_addr    = r_baddr;
    assign o_access_bytes = r_abytes;
    assign o_access_write = r_awrite;
    assign o_line_end     = r_lend;
    assign o_burst_done   = r_bdone;
    assign o_queue_used   = r_qused;

endmodule

// ===== rtl/burst_to_bank_line_splitter_core.sv =====
// Top level of the burst-to-bank line splitter: controller plus datapath.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low. Mode 0 queues a
// burst (base, byte count, read/write) and yields one result: a rejection is
// registered from the decode state, an accepted burst from the head-load
// state that follows the queue write in decode. Mode 1 cuts one line from
// the active burst and yields one bank access per bank word touched, one per
// cycle, the last marked with o_line_end; the first access is registered from
// the emit state, which follows decode directly, or follows a head-load state
// when the line finishes its burst and the next queued burst is loaded first.
// An issue with no active burst or a zero line limit yields a single
// non-access result, registered from the decode state. A transaction runs
// from capture through decode, the head-load state where needed and the emit
// state for a line's accesses. The sequencing state machine handles one
// transaction at a time, so the issue rate is set by the access loop: up to
// one line of bank-count accesses (16 at defaults) per transaction. Each
// result is shown for exactly one cycle with o_strobe high; the receiver
// cannot stall it and must take it on that cycle. busy drops as the last
// result is registered, so the next transaction may start while that result
// is on the ports.
// Configuration writes (i_cfg_we) take effect at once and are to be made only
// while busy is low.

module burst_to_bank_line_splitter_core
    import bbls_pkg::*;
#(
    parameter int NUM_BANKS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_burst_base,
    input  logic [23:0] i_burst_bytes,
    input  logic        i_write_flag,
    input  logic [23:0] i_line_limit,
    // result side
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [4:0]  o_bank_index,
    output logic [31:0] o_bank_addr,
    output logic [4:0]  o_access_bytes,
    output logic        o_access_write,
    output logic        o_line_end,
    output logic        o_burst_done,
    output logic [4:0]  o_queue_used
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Controller: decides per transaction which datapath steps run
    bbls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath: queue, active burst, line cutting and the result register
    bbls_dpath #(
        .NUM_BANKS   (NUM_BANKS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_burst_base   (i_burst_base),
        .i_burst_bytes  (i_burst_bytes),
        .i_write_flag   (i_write_flag),
        .i_line_limit   (i_line_limit),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_bank_index   (o_bank_index),
        .o_bank_addr    (o_bank_addr),
        .o_access_bytes (o_access_bytes),
        .o_access_write (o_access_write),
        .o_line_end     (o_line_end),
        .o_burst_done   (o_burst_done),
        .o_queue_used   (o_queue_used)
    );

endmodule

// ===== sim/bbls_tb_pkg.sv =====
// Scoreboard class and transaction types for the burst-to-bank line splitter bench.
`timescale 1ns / 1ps

package bbls_tb_pkg;
    import bbls_pkg::*;

    localparam int NUM_BANKS      = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int COUNT_LOG2_CAP = 5;
    localparam int REPORT_LINES   = 40;

    typedef struct {
        logic        mode;
        logic [31:0] base;
        logic [23:0] nbytes;
        logic        wr;
        logic [23:0] limit;
    } split_cmd_t;

    typedef struct {
        logic [1:0]  status;
        logic [4:0]  bank;
        logic [31:0] addr;
        logic [4:0]  nbytes;
        logic        wr;
        logic        line_end;
        logic        done;
        logic [4:0]  used;
    } split_result_t;

    class splitter_scoreboard;
        // pending bursts, ring buffer
        logic [31:0] burst_base_q[QUEUE_DEPTH];
        logic [23:0] burst_len_q[QUEUE_DEPTH];
        logic        burst_wr_q[QUEUE_DEPTH];
        int unsigned queued;
        int unsigned head;
        logic [31:0] cur_addr;
        logic [23:0] cur_left;
        // register copies
        logic [2:0]  width_log2;
        logic [2:0]  count_log2;
        logic [31:0] local_base;
        logic [4:0]  queue_limit;

        split_result_t expected_results[$];
        int errors;

        function new();
            queued      = 0;
            head        = 0;
            cur_addr    = '0;
            cur_left    = '0;
            width_log2  = 3'd2;
            count_log2  = 3'd4;
            local_base  = '0;
            queue_limit = 5'd4;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_BANK_WIDTH_LOG2: width_log2  = data[2:0];
                CFG_BANK_COUNT_LOG2: count_log2  = data[2:0];
                CFG_LOCAL_BASE:      local_base  = data;
                CFG_QUEUE_LIMIT:     queue_limit = data[4:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width_log2();
            return (width_log2 > WIDTH_LOG2_MAX) ? int'(WIDTH_LOG2_MAX) : int'(width_log2);
        endfunction

        function int unsigned eff_count_log2();
            int unsigned c;
            c = (count_log2 > COUNT_LOG2_CAP) ? COUNT_LOG2_CAP : count_log2;
            while (c > 0 && (1 << c) > NUM_BANKS) c--;
            return c;
        endfunction

        function int unsigned line_bytes();
            return 1 << (eff_width_log2() + eff_count_log2());
        endfunction

        function int unsigned slot_limit();
            return (queue_limit < QUEUE_DEPTH) ? queue_limit : QUEUE_DEPTH;
        endfunction

        function void load_head();
            if (cur_left == 0 && queued > 0) begin
                cur_addr = burst_base_q[head];
                cur_left = burst_len_q[head];
            end
        endfunction

        // Append one prediction at the tail of the expected list.
        function void expect_result(split_result_t r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void push_flag(logic [1:0] st);
            split_result_t r;
            r.status   = st;
            r.bank     = '0;
            r.addr     = '0;
            r.nbytes   = '0;
            r.wr       = 1'b0;
            r.line_end = 1'b1;
            r.done     = 1'b0;
            r.used     = 5'(queued);
            expect_result(r);
        endfunction

        // Predict the results of one accepted transaction.
        function void note_command(split_cmd_t c);
            int unsigned wl, width, nbanks, lw, size, to_bound, off, chunk, tail;
            logic [31:0] first, a;
            logic        wr, done;
            split_result_t r;
            if (c.mode == MODE_ENQUEUE) begin
                if (c.nbytes == 0 || queued >= slot_limit()) begin
                    push_flag(STAT_REJECTED);
                end else begin
                    tail = (head + queued) % QUEUE_DEPTH;
                    burst_base_q[tail] = c.base;
                    burst_len_q[tail]  = c.nbytes;
                    burst_wr_q[tail]   = c.wr;
                    queued++;
                    load_head();
                    push_flag(STAT_ACCEPTED);
                end
                return;
            end
            if (cur_left == 0 || queued == 0) begin
                push_flag(STAT_NO_BURST);
                return;
            end
            if (c.limit == 0) begin
                push_flag(STAT_REJECTED);
                return;
            end
            wl     = eff_width_log2();
            width  = 1 << wl;
            nbanks = 1 << eff_count_log2();
            lw     = line_bytes();
            size   = cur_left;
            if (size > c.limit) size = c.limit;
            if (size > lw) size = lw;
            to_bound = lw - (cur_addr & (lw - 1));
            if (size > to_bound) size = to_bound;
            wr       = burst_wr_q[head];
            first    = cur_addr;
            cur_addr = first + size;
            cur_left = cur_left - size;
            done     = (cur_left == 0);
            if (done) begin
                head = (head + 1) % QUEUE_DEPTH;
                queued--;
                load_head();
            end
            // one access per bank word touched
            off = 0;
            while (off < size) begin
                a     = first + off;
                chunk = width - (a & (width - 1));
                if (chunk > size - off) chunk = size - off;
                off += chunk;
                r.status   = STAT_ACCESS;
                r.bank     = 5'((a >> wl) & (nbanks - 1));
                r.addr     = a - local_base;
                r.nbytes   = 5'(chunk);
                r.wr       = wr;
                r.line_end = (off >= size);
                r.done     = done;
                r.used     = 5'(queued);
                expect_result(r);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_LINES) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report($sformatf("%s got %h expected %h", name, got_v, want_v));
        endtask

        task check_result(split_result_t got);
            split_result_t want;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result status %0d bank %0d addr %h",
                                 got.status, got.bank, got.addr));
                return;
            end
            want = expected_results.pop_front();
            check_field("status",       32'(got.status),   32'(want.status));
            check_field("bank_index",   32'(got.bank),     32'(want.bank));
            check_field("bank_addr",    got.addr,          want.addr);
            check_field("access_bytes", 32'(got.nbytes),   32'(want.nbytes));
            check_field("access_write", 32'(got.wr),       32'(want.wr));
            check_field("line_end",     32'(got.line_end), 32'(want.line_end));
            check_field("burst_done",   32'(got.done),     32'(want.done));
            check_field("queue_used",   32'(got.used),     32'(want.used));
        endtask
    endclass

endpackage

// ===== sim/tb.sv =====
// Testbench top: drives bursts, issues and register writes, checks every bank access.
`timescale 1ns / 1ps

module tb;
    import bbls_pkg::*;
    import bbls_tb_pkg::*;

    // Generous: the slowest legal run is far below this.
    localparam int CYCLE_LIMIT = 400000;
    // Longest line is 16 accesses plus capture, decode and head reload.
    localparam int TAIL_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [31:0] i_burst_base;
    logic [23:0] i_burst_bytes;
    logic        i_write_flag;
    logic [23:0] i_line_limit;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [4:0]  o_bank_index;
    logic [31:0] o_bank_addr;
    logic [4:0]  o_access_bytes;
    logic        o_access_write;
    logic        o_line_end;
    logic        o_burst_done;
    logic [4:0]  o_queue_used;

    splitter_scoreboard sb;
    int unsigned cycles = 0;
    int unsigned items_done = 0;
    int unsigned idle_pct = 0;

    burst_to_bank_line_splitter_core #(
        .NUM_BANKS  (NUM_BANKS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (.*);

    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a missing result ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result monitor. Strobed results cannot be held off, so take every
    // strobe cycle as an accepted result. Values read here are the ones
    // present before this edge.
    always @(posedge i_clk) begin
        split_result_t got;
        if (i_rst_n && o_strobe) begin
            got.status   = o_status;
            got.bank     = o_bank_index;
            got.addr     = o_bank_addr;
            got.nbytes   = o_access_bytes;
            got.wr       = o_access_write;
            got.line_end = o_line_end;
            got.done     = o_burst_done;
            got.used     = o_queue_used;
            sb.check_result(got);
        end
    end

    // Present one transaction and hold it until the edge where busy is low.
    // start stays high on return so back-to-back transactions never drop it.
    task automatic send_cmd(split_cmd_t c);
        start         <= 1'b1;
        i_mode        <= c.mode;
        i_burst_base  <= c.base;
        i_burst_bytes <= c.nbytes;
        i_write_flag  <= c.wr;
        i_line_limit  <= c.limit;
        do @(posedge i_clk); while (busy);
        sb.note_command(c);
        items_done++;
    endtask

    // Unused fields carry random junk: the block must ignore them.
    task automatic enqueue(logic [31:0] base, logic [23:0] nbytes, logic wr);
        split_cmd_t c;
        c.mode   = MODE_ENQUEUE;
        c.base   = base;
        c.nbytes = nbytes;
        c.wr     = wr;
        c.limit  = 24'($urandom);
        send_cmd(c);
    endtask

    task automatic issue(logic [23:0] limit);
        split_cmd_t c;
        c.mode   = MODE_ISSUE;
        c.base   = $urandom;
        c.nbytes = 24'($urandom);
        c.wr     = 1'($urandom_range(1));
        c.limit  = limit;
        send_cmd(c);
    endtask

    task automatic pause_sender(int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off the sender until every predicted result has shown up.
    task automatic wait_results(int unsigned extra);
        start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0 || busy);
        repeat (extra) @(posedge i_clk);
    endtask

    // Writes all four registers back to back; only called while idle.
    task automatic write_config(logic [2:0] bw, logic [2:0] bc, logic [31:0] base,
                                logic [4:0] ql);
        logic [1:0]  regs[4];
        logic [31:0] vals[4];
        regs = '{CFG_BANK_WIDTH_LOG2, CFG_BANK_COUNT_LOG2, CFG_LOCAL_BASE, CFG_QUEUE_LIMIT};
        vals = '{32'(bw), 32'(bc), base, 32'(ql)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.write_reg(regs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic reconfigure(logic [2:0] bw, logic [2:0] bc, logic [31:0] base,
                               logic [4:0] ql, int unsigned pct);
        wait_results(2);
        write_config(bw, bc, base, ql);
        idle_pct = pct;
    endtask

    // Gap after a transaction: occasional drain, otherwise a random idle burst.
    task automatic gap();
        if (idle_pct > 0 && $urandom_range(99) < 4)
            wait_results(0);
        else if ($urandom_range(99) < idle_pct)
            pause_sender($urandom_range(12, 1));
    endtask

    // Bases: mostly anywhere, some close to the 2^32 wrap, some near zero.
    function automatic logic [31:0] pick_base();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom;
        if (roll < 85) return 32'hFFFF_FFFF - $urandom_range(300, 0);
        return $urandom_range(1023, 0);
    endfunction

    // Keep bursts a few lines long so the queue drains in reasonable time.
    function automatic logic [23:0] pick_burst_len();
        int unsigned lw, roll, hi;
        lw   = sb.line_bytes();
        roll = $urandom_range(99);
        hi   = (8 * lw > 512) ? 512 : 8 * lw;
        if (roll < 70) return 24'($urandom_range(2 * lw, 1));
        if (roll < 95) return 24'($urandom_range(hi, 1));
        return (roll < 98) ? 24'(lw) : 24'd1;
    endfunction

    function automatic logic [23:0] pick_line_limit();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 24'($urandom_range(24'hFF_FFFF, 1));
        if (roll < 85) return 24'($urandom_range(sb.line_bytes(), 1));
        return 24'($urandom_range(4, 1));
    endfunction

    // Off-path transactions: zero-length bursts, zero limits, pushes into a
    // full queue (full-range lengths, always rejected) and issues on nothing.
    task automatic noise_item();
        case ($urandom_range(3))
            0: enqueue($urandom, 24'd0, 1'($urandom_range(1)));
            1: issue(24'd0);
            2: begin
                if (sb.queued >= sb.slot_limit())
                    enqueue($urandom, 24'($urandom_range(24'hFF_FFFF, 1)),
                            1'($urandom_range(1)));
                else
                    issue(24'($urandom));
            end
            default: issue(pick_line_limit());
        endcase
    endtask

    // Fill the queue (sometimes one past full), then issue lines until all
    // bursts are drained, with occasional refills and noise in between.
    task automatic burst_sequence();
        int unsigned tries;
        tries = $urandom_range(sb.slot_limit() + 1, 1);
        repeat (tries) begin
            if (sb.queued >= sb.slot_limit())
                enqueue(pick_base(), 24'($urandom_range(24'hFF_FFFF, 1)),
                        1'($urandom_range(1)));
            else
                enqueue(pick_base(), pick_burst_len(), 1'($urandom_range(1)));
            gap();
        end
        while (sb.queued > 0) begin
            if ($urandom_range(99) < 10)
                noise_item();
            else if ($urandom_range(99) < 15 && sb.queued < sb.slot_limit())
                enqueue(pick_base(), pick_burst_len(), 1'($urandom_range(1)));
            else
                issue(pick_line_limit());
            gap();
        end
    endtask

    task automatic random_phase(int unsigned n);
        int unsigned goal;
        goal = items_done + n;
        while (items_done < goal) begin
            if ($urandom_range(99) < 85) begin
                burst_sequence();
            end else begin
                noise_item();
                gap();
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_BANK_WIDTH_LOG2;
        i_cfg_data    <= '0;
        start         <= 1'b0;
        i_mode        <= MODE_ENQUEUE;
        i_burst_base  <= '0;
        i_burst_bytes <= '0;
        i_write_flag  <= 1'b0;
        i_line_limit  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset configuration (4-byte banks, 16 banks, 64-byte line).
        issue(24'hFF_FFFF);                    // nothing queued
        enqueue(32'h0, 24'd0, 1'b0);           // zero length is rejected
        enqueue(32'hFFFF_FFF3, 24'd40, 1'b1);  // write burst wrapping past 2^32
        issue(24'd0);                          // zero line limit, burst untouched
        issue(24'hFF_FFFF);                    // cut at the line boundary
        issue(24'd1);                          // cut by the caller's limit
        issue(24'hFF_FFFF);                    // finishes the burst
        issue(24'd5);                          // queue empty again
        wait_results(0);
        enqueue(32'h0000_1000, 24'd64, 1'b0);  // exactly one aligned line
        enqueue(32'hFFFF_FFFF, 24'd1, 1'b1);   // single byte at the top address
        enqueue(32'h0000_0007, 24'd100, 1'b0); // unaligned start
        enqueue(32'hAAAA_5555, 24'd3, 1'b1);   // queue now full
        enqueue(32'h5555_AAAA, 24'hFF_FFFF, 1'b1); // rejected: full
        while (sb.queued > 0) issue(24'hFF_FFFF);

        // Byte-wide single bank: one-byte lines, one-deep queue.
        reconfigure(3'd0, 3'd0, 32'h0, 5'd1, 40);
        random_phase(25);
        // Width and count above their caps; base subtraction wraps.
        reconfigure(3'd7, 3'd7, 32'hFFFF_FFFF, 5'd31, 0);
        random_phase(30);
        // Zero queue limit: every burst is turned away.
        reconfigure(3'd4, 3'd5, $urandom, 5'd0, 30);
        random_phase(20);
        repeat (3) begin
            reconfigure(3'($urandom_range(7, 0)), 3'($urandom_range(7, 0)), $urandom,
                        5'($urandom_range(31, 1)), ($urandom_range(1) == 1) ? 50 : 0);
            random_phase(30);
        end

        // Last stretch: no idling, then a full-length burst left mostly pending.
        reconfigure(3'd2, 3'd4, $urandom, 5'd16, 0);
        random_phase(30);
        enqueue(pick_base(), 24'hFF_FFFF, 1'b0);
        repeat (3) issue(24'hFF_FFFF);

        wait_results(TAIL_CYCLES);
        if (sb.expected_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
